@@ rtl/core/slc_pkg.sv @@
// Shared types and constants for the serial line editor.
// Standalone package; used by slc_ctrl, slc_seq and the top level in rtl/core.
`default_nettype none
package slc_pkg;

  localparam int unsigned LineDepthDef = 256;
  localparam int unsigned CapWidth     = 9;
  localparam int unsigned CountWidth   = 16;

  localparam logic [1:0] KIND_ECHO = 2'd0;
  localparam logic [1:0] KIND_DONE = 2'd1;
  localparam logic [1:0] KIND_READ = 2'd2;

  localparam logic CMD_RX   = 1'b0;
  localparam logic CMD_READ = 1'b1;

  localparam logic [7:0] CH_DEL = 8'h7F;
  localparam logic [7:0] CH_ESC = 8'h1B;
  localparam logic [7:0] CH_LBR = 8'h5B;
  localparam logic [7:0] CH_A   = 8'h41;
  localparam logic [7:0] CH_D   = 8'h44;
  localparam logic [7:0] CH_CR  = 8'h0D;
  localparam logic [7:0] CH_LF  = 8'h0A;
  localparam logic [7:0] CH_BS  = 8'h08;
  localparam logic [7:0] CH_SP  = 8'h20;

  localparam logic [1:0] ESC_IDLE = 2'd0;
  localparam logic [1:0] ESC_SEEN = 2'd1;
  localparam logic [1:0] ESC_CSI  = 2'd2;

  typedef enum logic [1:0] {
    OP_READ,
    OP_CHAR,
    OP_BKSP,
    OP_NEWL
  } slc_op_e;

  typedef struct packed {
    slc_op_e    op;
    logic [7:0] data;
    logic [7:0] len;
    logic       ovf;
    logic       oob;
  } slc_item_t;

endpackage
`default_nettype wire

@@ rtl/core/slc_if.sv @@
// Request and result channel interfaces for the serial line editor.
// No dependencies.
`default_nettype none
interface slc_in_if;
  logic       valid;
  logic       ready;
  logic       command;
  logic [7:0] rx_byte;
  logic [7:0] read_index;

  modport source (output valid, command, rx_byte, read_index, input ready);
  modport sink (input valid, command, rx_byte, read_index, output ready);
endinterface

interface slc_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] kind;
  logic [7:0] data_byte;
  logic [7:0] line_length;
  logic       overflow;
  logic       last;

  modport source (output valid, kind, data_byte, line_length, overflow, last,
                  input ready);
  modport sink (input valid, kind, data_byte, line_length, overflow, last,
                output ready);
endinterface
`default_nettype wire

@@ rtl/core/slc_store.sv @@
// Line store: one write port, one registered read port.
// No package dependencies.
`default_nettype none
module slc_store #(
  parameter int unsigned LINE_DEPTH = 256
) (
  input  wire logic                          clk_i,
  input  wire logic                          we_i,
  input  wire logic [$clog2(LINE_DEPTH)-1:0] waddr_i,
  input  wire logic [7:0]                    wdata_i,
  input  wire logic                          re_i,
  input  wire logic [$clog2(LINE_DEPTH)-1:0] raddr_i,
  output      logic [7:0]                    rdata_o
);

  logic [7:0] mem_q [LINE_DEPTH];
  logic [7:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule
`default_nettype wire

@@ rtl/core/slc_ctrl.sv @@
// Editor control: byte mapping, escape filter, character count, capacity.
// Depends on slc_pkg; drives the line store ports and the result sequencer.
`default_nettype none
module slc_ctrl #(
  parameter int unsigned LINE_DEPTH = slc_pkg::LineDepthDef
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_we_i,
  input  wire logic [slc_pkg::CapWidth-1:0]  cfg_data_i,
  input  wire logic                          accept_i,
  input  wire logic                          command_i,
  input  wire logic [7:0]                    rx_byte_i,
  input  wire logic [7:0]                    read_index_i,
  output      logic                          item_v_o,
  output      slc_pkg::slc_item_t            item_o,
  output      logic                          we_o,
  output      logic [$clog2(LINE_DEPTH)-1:0] waddr_o,
  output      logic [7:0]                    wdata_o,
  output      logic                          re_o,
  output      logic [$clog2(LINE_DEPTH)-1:0] raddr_o
);

  localparam int unsigned AW     = $clog2(LINE_DEPTH);
  localparam int unsigned IW     = (AW > 8) ? AW : 8;
  localparam int unsigned CapLim = (LINE_DEPTH < 256) ? LINE_DEPTH : 256;
  localparam int unsigned CW     = slc_pkg::CountWidth;

  logic [slc_pkg::CapWidth-1:0] cfg_q;
  logic [slc_pkg::CapWidth-1:0] cap;
  logic [slc_pkg::CapWidth-1:0] cap_m1;
  logic [1:0]                   phase_q, phase_d;
  logic [CW-1:0]                count_q, count_d;
  logic [7:0]                   ch;
  logic                         drop;
  logic [IW-1:0]                idx_ext;
  logic                         in_range;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q   <= slc_pkg::CapWidth'(256);
      phase_q <= slc_pkg::ESC_IDLE;
      count_q <= '0;
    end else begin
      if (cfg_we_i) begin
        cfg_q <= cfg_data_i;
      end
      phase_q <= phase_d;
      count_q <= count_d;
    end
  end

  always_comb begin
    if (cfg_q == '0) begin
      cap = slc_pkg::CapWidth'(1);
    end else if (cfg_q > slc_pkg::CapWidth'(CapLim)) begin
      cap = slc_pkg::CapWidth'(CapLim);
    end else begin
      cap = cfg_q;
    end
  end
  assign cap_m1 = cap - slc_pkg::CapWidth'(1);

  assign idx_ext  = IW'(read_index_i);
  assign raddr_o  = idx_ext[AW-1:0];
  assign in_range = {5'd0, read_index_i} < 13'(LINE_DEPTH);
  assign waddr_o  = count_q[AW-1:0];

  always_comb begin
    if (rx_byte_i == slc_pkg::CH_DEL) begin
      ch = slc_pkg::CH_BS;
    end else if (rx_byte_i == slc_pkg::CH_CR) begin
      ch = slc_pkg::CH_LF;
    end else begin
      ch = rx_byte_i;
    end
  end

  always_comb begin
    phase_d  = phase_q;
    count_d  = count_q;
    drop     = 1'b0;
    item_v_o = 1'b0;
    item_o   = '{op: slc_pkg::OP_CHAR, data: ch, len: 8'd0, ovf: 1'b0, oob: 1'b0};
    we_o     = 1'b0;
    wdata_o  = ch;
    re_o     = 1'b0;
    if (accept_i) begin
      if (command_i == slc_pkg::CMD_READ) begin
        re_o       = 1'b1;
        item_v_o   = 1'b1;
        item_o.op  = slc_pkg::OP_READ;
        item_o.oob = !in_range;
      end else begin
        if (ch == slc_pkg::CH_ESC) begin
          phase_d = slc_pkg::ESC_SEEN;
          drop    = 1'b1;
        end else if (phase_q == slc_pkg::ESC_SEEN) begin
          if (ch == slc_pkg::CH_LBR) begin
            phase_d = slc_pkg::ESC_CSI;
            drop    = 1'b1;
          end else begin
            phase_d = slc_pkg::ESC_IDLE;
          end
        end else if (phase_q != slc_pkg::ESC_IDLE) begin
          phase_d = slc_pkg::ESC_IDLE;
          drop    = (ch >= slc_pkg::CH_A) && (ch <= slc_pkg::CH_D);
        end
        if (!drop) begin
          if (ch == slc_pkg::CH_BS) begin
            if (count_q != '0) begin
              item_v_o  = 1'b1;
              item_o.op = slc_pkg::OP_BKSP;
              count_d   = count_q - CW'(1);
            end
          end else if (ch == slc_pkg::CH_LF) begin
            item_v_o  = 1'b1;
            item_o.op = slc_pkg::OP_NEWL;
            count_d   = '0;
            if (count_q < CW'(cap)) begin
              we_o       = 1'b1;
              wdata_o    = 8'd0;
              item_o.len = count_q[7:0];
            end else begin
              item_o.len = cap_m1[7:0];
              item_o.ovf = 1'b1;
            end
          end else begin
            item_v_o = 1'b1;
            we_o     = count_q < CW'(cap_m1);
            if (count_q != {CW{1'b1}}) begin
              count_d = count_q + CW'(1);
            end
          end
        end
      end
    end
  end

endmodule
`default_nettype wire

@@ rtl/core/slc_seq.sv @@
// Result sequencer: holds one item and emits its one to three results.
// Depends on slc_pkg; fed by slc_ctrl and the line store read data.
`default_nettype none
module slc_seq (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               accept_i,
  input  wire logic               item_v_i,
  input  wire slc_pkg::slc_item_t item_i,
  input  wire logic [7:0]         rdata_i,
  output      logic               in_ready_o,
  output      logic               out_valid_o,
  input  wire logic               out_ready_i,
  output      logic [1:0]         kind_o,
  output      logic [7:0]         data_byte_o,
  output      logic [7:0]         line_length_o,
  output      logic               overflow_o,
  output      logic               last_o
);

  logic               valid_q;
  logic [1:0]         step_q;
  slc_pkg::slc_item_t item_q;
  logic               is_last;

  assign is_last = (item_q.op == slc_pkg::OP_READ) || (item_q.op == slc_pkg::OP_CHAR) ||
                   (step_q == 2'd2);
  assign in_ready_o  = !valid_q || (out_ready_i && is_last);
  assign out_valid_o = valid_q;
  assign last_o      = is_last;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      step_q  <= 2'd0;
    end else if (accept_i) begin
      valid_q <= item_v_i;
      step_q  <= 2'd0;
    end else if (valid_q && out_ready_i) begin
      if (is_last) begin
        valid_q <= 1'b0;
      end else begin
        step_q <= step_q + 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept_i) begin
      item_q <= item_i;
    end
  end

  always_comb begin
    kind_o        = slc_pkg::KIND_ECHO;
    data_byte_o   = 8'd0;
    line_length_o = 8'd0;
    overflow_o    = 1'b0;
    case (item_q.op)
      slc_pkg::OP_READ: begin
        kind_o      = slc_pkg::KIND_READ;
        data_byte_o = item_q.oob ? 8'd0 : rdata_i;
      end
      slc_pkg::OP_CHAR: begin
        data_byte_o = item_q.data;
      end
      slc_pkg::OP_BKSP: begin
        data_byte_o = (step_q == 2'd1) ? slc_pkg::CH_SP : slc_pkg::CH_BS;
      end
      slc_pkg::OP_NEWL: begin
        case (step_q)
          2'd0: data_byte_o = slc_pkg::CH_LF;
          2'd1: data_byte_o = slc_pkg::CH_CR;
          default: begin
            kind_o        = slc_pkg::KIND_DONE;
            line_length_o = item_q.len;
            overflow_o    = item_q.ovf;
          end
        endcase
      end
      default: begin
        kind_o = slc_pkg::KIND_ECHO;
      end
    endcase
  end

endmodule
`default_nettype wire

@@ rtl/core/serial_line_editor_core.sv @@
// Serial line editor top level: control, line store and result sequencer.
// Depends on slc_pkg, slc_if, slc_ctrl, slc_store and slc_seq.
//
// Usage: requests arrive on req_i (command, rx_byte, read_index); results
// leave on res_o (kind, data_byte, line_length, overflow, last). A request is
// taken on a clock edge with valid and ready high. A received byte causes
// zero, one or three results; a read request causes one result.
// The first result of a request is valid in the cycle after it is taken. A
// request with one result may follow every cycle while res_o.ready is high;
// backspace and newline hold the result register for their three results.
// Store reads use the registered port of the line memory, so read data is
// ready together with the result register.
// The line capacity register is written through cfg_we_i / cfg_data_i only while
// the block is idle; the user must keep to this, the block does not enforce it.
// Reset: capacity 256, escape filter idle, character count zero; the line
// memory is not cleared.
// Stall: when res_o.ready is low the current result holds and req_i.ready
// drops until the last result of the held request is taken.
`default_nettype none
module serial_line_editor_core #(
  parameter int unsigned LINE_DEPTH = slc_pkg::LineDepthDef
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         cfg_we_i,
  input  wire logic [slc_pkg::CapWidth-1:0] cfg_data_i,
  slc_in_if.sink                            req_i,
  slc_out_if.source                         res_o
);

  localparam int unsigned AW = $clog2(LINE_DEPTH);

  logic               accept;
  logic               item_v;
  slc_pkg::slc_item_t item;
  logic               we;
  logic [AW-1:0]      waddr;
  logic [7:0]         wdata;
  logic               re;
  logic [AW-1:0]      raddr;
  logic [7:0]         rdata;

  assign accept = req_i.valid && req_i.ready;

  slc_ctrl #(
    .LINE_DEPTH (LINE_DEPTH)
  ) u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_data_i   (cfg_data_i),
    .accept_i     (accept),
    .command_i    (req_i.command),
    .rx_byte_i    (req_i.rx_byte),
    .read_index_i (req_i.read_index),
    .item_v_o     (item_v),
    .item_o       (item),
    .we_o         (we),
    .waddr_o      (waddr),
    .wdata_o      (wdata),
    .re_o         (re),
    .raddr_o      (raddr)
  );

  slc_store #(
    .LINE_DEPTH (LINE_DEPTH)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .re_i    (re),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  slc_seq u_seq (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .accept_i      (accept),
    .item_v_i      (item_v),
    .item_i        (item),
    .rdata_i       (rdata),
    .in_ready_o    (req_i.ready),
    .out_valid_o   (res_o.valid),
    .out_ready_i   (res_o.ready),
    .kind_o        (res_o.kind),
    .data_byte_o   (res_o.data_byte),
    .line_length_o (res_o.line_length),
    .overflow_o    (res_o.overflow),
    .last_o        (res_o.last)
  );

`ifndef ASSERT_OFF
  a_busy_no_req: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.valid && !res_o.last |-> !req_i.ready)
    else $error("request taken while results pending");

  a_done_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.valid && (res_o.kind == slc_pkg::KIND_DONE) |-> res_o.last)
    else $error("line complete not last result");

  a_read_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && (req_i.command == slc_pkg::CMD_READ)
    |=> res_o.valid && (res_o.kind == slc_pkg::KIND_READ))
    else $error("read request without read result");
`endif

endmodule
`default_nettype wire

@@ tb/serial_line_editor_core_test.sv @@
`timescale 1ns / 100ps
// Self-checking testbench for serial_line_editor_core: echo, line completion and read-back.
// Depends on slc_pkg, slc_if and the serial_line_editor_core RTL.
module serial_line_editor_core_test;

  localparam int unsigned CYCLE_LIMIT = 2_000_000;
  localparam int unsigned CAP_MAX =
    (slc_pkg::LineDepthDef < 256) ? slc_pkg::LineDepthDef : 256;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] data;
    logic [7:0] len;
    logic       ovf;
    logic       last;
  } term_out_t;

  logic                         clk_i;
  logic                         rst_ni;
  logic                         cfg_we_i;
  logic [slc_pkg::CapWidth-1:0] cfg_data_i;

  slc_in_if  req_if ();
  slc_out_if res_if ();

  serial_line_editor_core dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_data_i (cfg_data_i),
    .req_i      (req_if),
    .res_o      (res_if)
  );

  // editor state mirror
  logic [slc_pkg::CapWidth-1:0]   cap_reg;
  logic [1:0]                     esc_phase;
  logic [slc_pkg::CountWidth-1:0] typed_count;
  logic [7:0]                     line_mem [0:slc_pkg::LineDepthDef-1];
  bit                             line_written [0:slc_pkg::LineDepthDef-1];
  int                             hi_written;
  term_out_t                      term_out_q [$];

  int unsigned fail_count;
  int unsigned cycle_count;
  bit          src_gaps_en;
  bit          sink_stall_en;
  int unsigned burst_left;
  int unsigned sink_run_left;
  logic        sink_run_val;
  int unsigned hold_off_left;

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("Regression FAIL");
    $finish;
  end

  function automatic void push_out(input logic [1:0] kind, input logic [7:0] data,
                                   input logic [7:0] len, input logic ovf,
                                   input logic last);
    term_out_t r;
    r.kind = kind;
    r.data = data;
    r.len  = len;
    r.ovf  = ovf;
    r.last = last;
    term_out_q.push_back(r);
  endfunction

  function automatic void store_char(input logic [7:0] pos, input logic [7:0] val);
    line_mem[pos]     = val;
    line_written[pos] = 1'b1;
    if (int'(pos) > hi_written) hi_written = int'(pos);
  endfunction

  function automatic void edit_request(input logic cmd, input logic [7:0] rx,
                                       input logic [7:0] idx);
    logic [7:0]  ch;
    logic        drop;
    int unsigned cap;
    if (cmd == slc_pkg::CMD_READ) begin
      push_out(slc_pkg::KIND_READ, line_mem[idx], 8'd0, 1'b0, 1'b1);
      return;
    end
    ch = rx;
    if (ch == slc_pkg::CH_DEL) ch = slc_pkg::CH_BS;
    else if (ch == slc_pkg::CH_CR) ch = slc_pkg::CH_LF;
    drop = 1'b0;
    if (ch == slc_pkg::CH_ESC) begin
      esc_phase = slc_pkg::ESC_SEEN;
      drop = 1'b1;
    end else if (esc_phase == slc_pkg::ESC_SEEN) begin
      if (ch == slc_pkg::CH_LBR) begin
        esc_phase = slc_pkg::ESC_CSI;
        drop = 1'b1;
      end else begin
        esc_phase = slc_pkg::ESC_IDLE;
      end
    end else if (esc_phase != slc_pkg::ESC_IDLE) begin
      esc_phase = slc_pkg::ESC_IDLE;
      drop = (ch >= slc_pkg::CH_A) && (ch <= slc_pkg::CH_D);
    end
    if (drop) return;
    cap = (cap_reg == 0) ? 1 : ((cap_reg > CAP_MAX) ? CAP_MAX : cap_reg);
    if (ch == slc_pkg::CH_BS) begin
      if (typed_count != 0) begin
        push_out(slc_pkg::KIND_ECHO, slc_pkg::CH_BS, 8'd0, 1'b0, 1'b0);
        push_out(slc_pkg::KIND_ECHO, slc_pkg::CH_SP, 8'd0, 1'b0, 1'b0);
        push_out(slc_pkg::KIND_ECHO, slc_pkg::CH_BS, 8'd0, 1'b0, 1'b1);
        typed_count--;
      end
    end else if (ch == slc_pkg::CH_LF) begin
      push_out(slc_pkg::KIND_ECHO, slc_pkg::CH_LF, 8'd0, 1'b0, 1'b0);
      push_out(slc_pkg::KIND_ECHO, slc_pkg::CH_CR, 8'd0, 1'b0, 1'b0);
      if (typed_count < cap) begin
        store_char(typed_count[7:0], 8'd0);
        push_out(slc_pkg::KIND_DONE, 8'd0, typed_count[7:0], 1'b0, 1'b1);
      end else begin
        push_out(slc_pkg::KIND_DONE, 8'd0, 8'(cap - 1), 1'b1, 1'b1);
      end
      typed_count = '0;
    end else begin
      push_out(slc_pkg::KIND_ECHO, ch, 8'd0, 1'b0, 1'b1);
      if (typed_count < cap - 1) store_char(typed_count[7:0], ch);
      if (typed_count != {slc_pkg::CountWidth{1'b1}}) typed_count++;
    end
  endfunction

  always @(posedge clk_i) begin : check_results
    term_out_t want;
    if (rst_ni && res_if.valid && res_if.ready) begin
      if (term_out_q.size() == 0) begin
        $error("unexpected result: kind %0d data %0h", res_if.kind, res_if.data_byte);
        fail_count++;
      end else begin
        want = term_out_q.pop_front();
        if (res_if.kind !== want.kind) begin
          $error("kind: expected %0d, got %0d", want.kind, res_if.kind);
          fail_count++;
        end
        if (res_if.data_byte !== want.data) begin
          $error("data_byte: expected %0h, got %0h", want.data, res_if.data_byte);
          fail_count++;
        end
        if (res_if.line_length !== want.len) begin
          $error("line_length: expected %0d, got %0d", want.len, res_if.line_length);
          fail_count++;
        end
        if (res_if.overflow !== want.ovf) begin
          $error("overflow: expected %0b, got %0b", want.ovf, res_if.overflow);
          fail_count++;
        end
        if (res_if.last !== want.last) begin
          $error("last: expected %0b, got %0b", want.last, res_if.last);
          fail_count++;
        end
      end
    end
  end

  // receiver: ready low during a hold-off, else its own ready/stall run pattern
  initial begin
    res_if.ready  = 1'b0;
    sink_run_left = 0;
    sink_run_val  = 1'b1;
    forever begin
      @(negedge clk_i);
      if (hold_off_left > 0) begin
        res_if.ready = 1'b0;
        hold_off_left--;
      end else if (!sink_stall_en) begin
        res_if.ready = 1'b1;
      end else begin
        if (sink_run_left == 0) begin
          sink_run_val  = ~sink_run_val;
          sink_run_left = sink_run_val ? $urandom_range(1, 12) : $urandom_range(1, 5);
        end
        sink_run_left--;
        res_if.ready = sink_run_val;
      end
    end
  end

  task automatic send_request(input logic cmd, input logic [7:0] rx, input logic [7:0] idx);
    int unsigned gap;
    if (src_gaps_en) begin
      if (burst_left == 0) begin
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
        repeat (gap) begin
          @(negedge clk_i);
          req_if.valid = 1'b0;
        end
        burst_left = $urandom_range(1, 16);
      end
      burst_left--;
    end
    @(negedge clk_i);
    req_if.valid      = 1'b1;
    req_if.command    = cmd;
    req_if.rx_byte    = rx;
    req_if.read_index = idx;
    forever begin
      @(posedge clk_i);
      if (req_if.ready) break;
    end
    edit_request(cmd, rx, idx);
  endtask

  task automatic send_rx(input logic [7:0] b);
    send_request(slc_pkg::CMD_RX, b, 8'($urandom_range(0, 255)));
  endtask

  task automatic send_read(input logic [7:0] idx);
    send_request(slc_pkg::CMD_READ, 8'($urandom_range(0, 255)), idx);
  endtask

  // only entries already written are read
  task automatic send_stored_read();
    int         tries;
    logic [7:0] idx;
    if (hi_written < 0) return;
    for (tries = 0; tries < 32; tries++) begin
      idx = 8'($urandom_range(0, hi_written));
      if (line_written[idx]) begin
        send_read(idx);
        return;
      end
    end
  endtask

  task automatic wait_idle();
    @(negedge clk_i);
    req_if.valid = 1'b0;
    while (term_out_q.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic set_capacity(input logic [slc_pkg::CapWidth-1:0] val);
    wait_idle();
    @(negedge clk_i);
    cfg_we_i   = 1'b1;
    cfg_data_i = val;
    @(posedge clk_i);
    cap_reg = val;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
  endtask

  task automatic test_line_basics();
    send_rx(slc_pkg::CH_BS);
    send_rx(slc_pkg::CH_DEL);
    send_rx(8'h61);
    send_rx(8'h00);
    send_rx(8'hFF);
    send_rx(slc_pkg::CH_DEL);
    send_rx(8'h62);
    send_rx(slc_pkg::CH_CR);
    send_read(8'd0);
    send_read(8'd1);
    send_read(8'd2);
    send_read(8'd3);
  endtask

  task automatic test_escape_filter();
    send_rx(slc_pkg::CH_ESC);
    send_read(8'd0);
    send_rx(slc_pkg::CH_LBR);
    send_rx(slc_pkg::CH_A);
    send_rx(slc_pkg::CH_ESC);
    send_rx(slc_pkg::CH_LBR);
    send_rx(slc_pkg::CH_D);
    send_rx(slc_pkg::CH_ESC);
    send_rx(slc_pkg::CH_ESC);
    send_rx(slc_pkg::CH_LBR);
    send_rx(slc_pkg::CH_A + 8'd1);
    send_rx(slc_pkg::CH_ESC);
    send_rx(8'h78);
    send_rx(slc_pkg::CH_ESC);
    send_rx(slc_pkg::CH_LBR);
    send_rx(8'h5A);
    send_rx(slc_pkg::CH_ESC);
    send_rx(slc_pkg::CH_DEL);
    send_rx(slc_pkg::CH_ESC);
    send_rx(slc_pkg::CH_LBR);
    send_rx(slc_pkg::CH_LBR);
    send_rx(slc_pkg::CH_LF);
  endtask

  task automatic test_capacity_extremes();
    set_capacity('0);
    send_rx(8'h71);
    send_rx(slc_pkg::CH_LF);
    send_rx(slc_pkg::CH_LF);
    send_read(8'd0);
    set_capacity(slc_pkg::CapWidth'(1));
    send_rx(8'h71);
    send_rx(8'h72);
    send_rx(slc_pkg::CH_CR);
    set_capacity({slc_pkg::CapWidth{1'b1}});
    send_rx(8'h61);
    send_rx(8'h62);
    send_rx(slc_pkg::CH_LF);
    send_read(8'd1);
    set_capacity(slc_pkg::CapWidth'(256));
  endtask

  task automatic test_long_lines();
    int k;
    src_gaps_en   = 1'b0;
    sink_stall_en = 1'b0;
    for (k = 0; k < 255; k++) send_rx(8'($urandom_range(8'h20, 8'h7E)));
    send_rx(slc_pkg::CH_CR);
    send_read(8'd255);
    send_read(8'd254);
    send_read(8'd128);
    send_read(8'd127);
    src_gaps_en   = 1'b1;
    sink_stall_en = 1'b1;
  endtask

  task automatic test_backpressure();
    int k;
    wait_idle();
    src_gaps_en = 1'b0;
    @(posedge clk_i);
    hold_off_left = 200;
    for (k = 0; k < 30; k++) begin
      case (k % 5)
        0: send_rx(slc_pkg::CH_BS);
        3: send_rx(slc_pkg::CH_CR);
        4: send_stored_read();
        default: send_rx(8'($urandom_range(8'h20, 8'h7E)));
      endcase
    end
    src_gaps_en = 1'b1;
  endtask

  task automatic test_random_traffic();
    int unsigned ph, sent, pick, len, k;
    for (ph = 0; ph < 5; ph++) begin
      case (ph)
        0: set_capacity(slc_pkg::CapWidth'(256));
        1: set_capacity(slc_pkg::CapWidth'(4));
        2: set_capacity(slc_pkg::CapWidth'($urandom_range(0, 511)));
        3: set_capacity(slc_pkg::CapWidth'(2));
        default: set_capacity({slc_pkg::CapWidth{1'b1}});
      endcase
      sent = 0;
      while (sent < 16) begin
        pick = $urandom_range(0, 99);
        if (pick < 12) begin
          send_stored_read();
          sent++;
        end else if (pick < 22) begin
          send_rx(8'($urandom_range(0, 255)));
          sent++;
        end else if (pick < 28) begin
          send_rx(slc_pkg::CH_ESC);
          if ($urandom_range(0, 1)) begin
            send_rx(slc_pkg::CH_LBR);
            sent++;
          end
          send_rx(8'($urandom_range(0, 255)));
          sent += 2;
        end else begin
          len = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40) : $urandom_range(0, 12);
          for (k = 0; k < len; k++) begin
            pick = $urandom_range(0, 99);
            if (pick < 8) begin
              send_rx((pick < 4) ? slc_pkg::CH_BS : slc_pkg::CH_DEL);
            end else if (pick < 12) begin
              send_rx(slc_pkg::CH_ESC);
              send_rx(slc_pkg::CH_LBR);
              send_rx(slc_pkg::CH_A + 8'($urandom_range(0, 3)));
              sent += 2;
            end else begin
              send_rx(8'($urandom_range(8'h20, 8'h7E)));
            end
            sent++;
          end
          send_rx($urandom_range(0, 1) ? slc_pkg::CH_CR : slc_pkg::CH_LF);
          sent++;
        end
      end
    end
  endtask

  initial begin
    rst_ni            = 1'b0;
    cfg_we_i          = 1'b0;
    cfg_data_i        = '0;
    req_if.valid      = 1'b0;
    req_if.command    = slc_pkg::CMD_RX;
    req_if.rx_byte    = 8'd0;
    req_if.read_index = 8'd0;
    fail_count        = 0;
    src_gaps_en       = 1'b1;
    sink_stall_en     = 1'b1;
    burst_left        = 0;
    hold_off_left     = 0;
    cap_reg           = slc_pkg::CapWidth'(256);
    esc_phase         = slc_pkg::ESC_IDLE;
    typed_count       = '0;
    hi_written        = -1;
    for (int i = 0; i < slc_pkg::LineDepthDef; i++) begin
      line_mem[i]     = 8'd0;
      line_written[i] = 1'b0;
    end
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_line_basics();
    test_escape_filter();
    test_capacity_extremes();
    test_long_lines();
    test_backpressure();
    test_random_traffic();
    wait_idle();

    if (fail_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
